// ===== hdl/sds_pkg.sv =====
// ----------------------------------------------------------------------------
// sds_pkg
// Shared constants and lookup tables for the sensory dissonance sum unit.
// ----------------------------------------------------------------------------
package sds_pkg;

    localparam int VOICE_SLOTS_DEF        = 4;
    localparam int PARTIALS_PER_VOICE_DEF = 16;

    localparam int FREQ_W  = 22;
    localparam int AMP_W   = 16;
    localparam int OUT_W   = 32;
    localparam int SUM_W   = 40;
    localparam int CBW_W   = 17;
    localparam int EXP_W   = 25;
    localparam int DVD_W   = 34;
    localparam int D_W     = 24;
    localparam int X_W     = 27;
    localparam int MA_W    = 33;
    localparam int MB_W    = 25;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int START_W = 6;

    localparam logic [2:0] ADDR_START_INDEX = 3'd0;

    // critical bandwidth in Q.4 Hz at 1024*k Hz
    function automatic logic [CBW_W-1:0] cbw_tab(input logic [4:0] idx);
        logic [CBW_W-1:0] v;
        case (idx)
            5'd0:    v = 17'd1600;
            5'd1:    v = 17'd2638;
            5'd2:    v = 17'd4937;
            5'd3:    v = 17'd7891;
            5'd4:    v = 17'd11304;
            5'd5:    v = 17'd15086;
            5'd6:    v = 17'd19178;
            5'd7:    v = 17'd23554;
            5'd8:    v = 17'd28174;
            5'd9:    v = 17'd33029;
            5'd10:   v = 17'd38093;
            5'd11:   v = 17'd43360;
            5'd12:   v = 17'd48797;
            5'd13:   v = 17'd54424;
            5'd14:   v = 17'd60221;
            5'd15:   v = 17'd66173;
            5'd16:   v = 17'd72280;
            default: v = 17'd72280;
        endcase
        return v;
    endfunction

    // exp(-n) in Q.24
    function automatic logic [EXP_W-1:0] exp_int(input logic [3:0] n);
        logic [EXP_W-1:0] v;
        case (n)
            4'd0:    v = 25'd16777216;
            4'd1:    v = 25'd6171993;
            4'd2:    v = 25'd2270549;
            4'd3:    v = 25'd835288;
            4'd4:    v = 25'd307286;
            4'd5:    v = 25'd113044;
            4'd6:    v = 25'd41587;
            4'd7:    v = 25'd15299;
            4'd8:    v = 25'd5628;
            4'd9:    v = 25'd2071;
            4'd10:   v = 25'd762;
            4'd11:   v = 25'd280;
            4'd12:   v = 25'd103;
            4'd13:   v = 25'd38;
            4'd14:   v = 25'd14;
            4'd15:   v = 25'd5;
            default: v = 25'd5;
        endcase
        return v;
    endfunction

    // exp(-k/16) in Q.24
    function automatic logic [EXP_W-1:0] exp_frac(input logic [4:0] k);
        logic [EXP_W-1:0] v;
        case (k)
            5'd0:    v = 25'd16777216;
            5'd1:    v = 25'd15760736;
            5'd2:    v = 25'd14805841;
            5'd3:    v = 25'd13908801;
            5'd4:    v = 25'd13066109;
            5'd5:    v = 25'd12274474;
            5'd6:    v = 25'd11530801;
            5'd7:    v = 25'd10832185;
            5'd8:    v = 25'd10175896;
            5'd9:    v = 25'd9559369;
            5'd10:   v = 25'd8980197;
            5'd11:   v = 25'd8436154;
            5'd12:   v = 25'd7924996;
            5'd13:   v = 25'd7444844;
            5'd14:   v = 25'd6993784;
            5'd15:   v = 25'd6570024;
            5'd16:   v = 25'd6171993;
            default: v = 25'd6171993;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/sensory_dissonance_sum_unit.sv =====
// ----------------------------------------------------------------------------
// sensory_dissonance_sum_unit
// Pairwise sensory dissonance of a loaded set of partials, one shared unit.
// ----------------------------------------------------------------------------
// usage
//   s_* stream loads one partial per transaction: tdata holds frequency
//   (unsigned Q14.8) and amplitude (Q1.15); tlast marks the final partial and
//   starts the sum. loading accepts one partial per cycle, s_tready stays high.
//   after tlast the sequencer walks every pair i<j with i >= start_index and
//   s_tready is low until the result is in the output register. the pair time
//   is dominated by the 34-step restoring divider for the bandwidth-normalised
//   distance; the multiplier is shared by all products. a full set of 64
//   partials holds 2016 pairs. m_* stream carries the Q16.16 dissonance. a
//   result waiting in the output register does not block loading of the next
//   set; a finished sum waits for the output register to free up when the
//   receiver stalls. start_index is written over the apb port at address 0;
//   the user must write it only while idle, the block itself does not enforce
//   this. reset clears the fill count, the sum, start_index and the output
//   valid; the partial store is not cleared, only loaded entries are ever used.
// ----------------------------------------------------------------------------
module sensory_dissonance_sum_unit #(
    parameter int VOICE_SLOTS        = sds_pkg::VOICE_SLOTS_DEF,
    parameter int PARTIALS_PER_VOICE = sds_pkg::PARTIALS_PER_VOICE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // frequency [21:0], amplitude [37:22], zero pad
    input  logic        s_tlast,   // last_partial
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // dissonance [31:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sds_pkg::*;

    localparam int CAP = VOICE_SLOTS * PARTIALS_PER_VOICE;
    localparam int AW  = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int CW  = (AW + 1 > START_W + 1) ? AW + 1 : START_W + 1;

    typedef enum logic [4:0] {
        S_IDLE, S_OUTER, S_LDI, S_INNER, S_LDJ, S_CMP, S_MCBW, S_CBW, S_DIV,
        S_XS, S_EF, S_EI, S_EM, S_EW, S_MA, S_MT, S_ACC, S_DONE
    } state_t;

    state_t state_reg;

    logic [FREQ_W+AMP_W-1:0] mem [CAP];
    logic [FREQ_W+AMP_W-1:0] rd_reg;
    logic [AW-1:0]           rd_addr;

    logic [CW-1:0]      count_reg, i_reg, j_reg;
    logic [START_W-1:0] start_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [FREQ_W-1:0]  fi_reg, fj_reg, lo_reg, diff_reg;
    logic [AMP_W-1:0]   ai_reg, aj_reg;
    logic [CBW_W-1:0]   cbw_reg;
    logic [17:0]        rem_reg;
    logic [DVD_W-1:0]   quo_reg;
    logic [5:0]         cnt_reg;
    logic [X_W-1:0]     x1_reg, x2_reg;
    logic               sel_reg;
    logic [EXP_W-1:0]   ef_reg, e1_reg, e2_reg, g_reg;
    logic [PROD_W-1:0]  mul_reg;
    logic               m_tvalid_reg;
    logic [OUT_W-1:0]   m_tdata_reg;

    logic [MA_W-1:0]   op_a;
    logic [MB_W-1:0]   op_b;
    logic              in_acc;
    logic              cfg_wr;
    logic [X_W-1:0]    x_cur;
    logic              x_big;
    logic [3:0]        x_n, x_k;
    logic [EXP_W-1:0]  f_lo, f_hi;
    logic [18:0]       div_sh;
    logic              div_ge;
    logic [D_W-1:0]    d_val;
    logic [28:0]       d23;
    logic [X_W-1:0]    d7;
    logic [SUM_W:0]    sum_ext;
    logic [CBW_W-1:0]  cbw_lo, cbw_hi;

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr == ADDR_START_INDEX);
    assign prdata   = (paddr == ADDR_START_INDEX) ? {26'd0, start_reg} : 32'd0;

    assign rd_addr = (state_reg == S_OUTER) ? i_reg[AW-1:0] : j_reg[AW-1:0];

    // exponent argument split
    assign x_cur = sel_reg ? x2_reg : x1_reg;
    assign x_big = |x_cur[X_W-1:20];
    assign x_n   = x_cur[19:16];
    assign x_k   = x_cur[15:12];
    assign f_lo  = exp_frac({1'b0, x_k});
    assign f_hi  = exp_frac({1'b0, x_k} + 5'd1);

    assign cbw_lo = cbw_tab({1'b0, lo_reg[21:18]});
    assign cbw_hi = cbw_tab({1'b0, lo_reg[21:18]} + 5'd1);

    assign div_sh = {rem_reg, quo_reg[DVD_W-1]};
    assign div_ge = (div_sh >= {2'b00, cbw_reg});

    assign d_val = quo_reg[D_W-1:0];
    assign d7    = ({3'd0, d_val} << 3) - {3'd0, d_val};
    assign d23   = ({5'd0, d_val} << 4) + ({5'd0, d_val} << 3) - {5'd0, d_val};

    assign sum_ext = {1'b0, sum_reg} + {13'd0, mul_reg[PROD_W-1:30]};

    // shared multiplier operand selection
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            S_MCBW:
            begin
                op_a = MA_W'(cbw_hi - cbw_lo);
                op_b = MB_W'(lo_reg[17:0]);
            end
            S_EF:
            begin
                op_a = MA_W'(f_lo - f_hi);
                op_b = MB_W'(x_cur[11:0]);
            end
            S_EM:
            begin
                op_a = MA_W'(exp_int(x_n));
                op_b = ef_reg;
            end
            S_MA:
            begin
                op_a = MA_W'(ai_reg);
                op_b = MB_W'(aj_reg);
            end
            S_MT:
            begin
                op_a = mul_reg[MA_W-1:0];
                op_b = g_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // partial store
    always_ff @(posedge clk)
    begin
        if (in_acc && (count_reg < CW'(CAP)))
        begin
            mem[count_reg[AW-1:0]] <= s_tdata[FREQ_W+AMP_W-1:0];
        end
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            start_reg    <= '0;
            sum_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            i_reg        <= '0;
            j_reg        <= '0;
            sel_reg      <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            mul_reg <= op_a * op_b;

            if (cfg_wr)
            begin
                start_reg <= pwdata[START_W-1:0];
            end

            // output register: load a finished sum or hand the result over
            if ((state_reg == S_DONE) && (!m_tvalid_reg || m_tready))
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (count_reg < CW'(CAP))
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        if (s_tlast)
                        begin
                            i_reg     <= CW'(start_reg);
                            sum_reg   <= '0;
                            state_reg <= S_OUTER;
                        end
                    end
                end
                S_OUTER:
                begin
                    state_reg <= (i_reg < count_reg) ? S_LDI : S_DONE;
                end
                S_LDI:
                begin
                    fi_reg    <= rd_reg[FREQ_W-1:0];
                    ai_reg    <= rd_reg[FREQ_W+AMP_W-1:FREQ_W];
                    j_reg     <= i_reg + 1'b1;
                    state_reg <= S_INNER;
                end
                S_INNER:
                begin
                    if (j_reg < count_reg)
                    begin
                        state_reg <= S_LDJ;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_OUTER;
                    end
                end
                S_LDJ:
                begin
                    fj_reg    <= rd_reg[FREQ_W-1:0];
                    aj_reg    <= rd_reg[FREQ_W+AMP_W-1:FREQ_W];
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (fi_reg < fj_reg)
                    begin
                        lo_reg   <= fi_reg;
                        diff_reg <= fj_reg - fi_reg;
                    end
                    else
                    begin
                        lo_reg   <= fj_reg;
                        diff_reg <= fi_reg - fj_reg;
                    end
                    state_reg <= S_MCBW;
                end
                S_MCBW:
                begin
                    state_reg <= S_CBW;
                end
                S_CBW:
                begin
                    cbw_reg   <= cbw_lo + mul_reg[CBW_W+17:18];
                    rem_reg   <= '0;
                    quo_reg   <= {diff_reg, 12'd0};
                    cnt_reg   <= 6'(DVD_W);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    // restoring division, one quotient bit per cycle
                    rem_reg <= div_ge ? 18'(div_sh - {2'b00, cbw_reg}) : div_sh[17:0];
                    quo_reg <= {quo_reg[DVD_W-2:0], div_ge};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == 6'd1)
                    begin
                        state_reg <= S_XS;
                    end
                end
                S_XS:
                begin
                    x1_reg    <= d7 >> 1;
                    x2_reg    <= d23[28:2];
                    sel_reg   <= 1'b0;
                    state_reg <= S_EF;
                end
                S_EF:
                begin
                    if (x_big)
                    begin
                        // argument of 16 or more gives zero
                        if (sel_reg)
                        begin
                            e2_reg    <= '0;
                            state_reg <= S_MA;
                        end
                        else
                        begin
                            e1_reg  <= '0;
                            sel_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        state_reg <= S_EI;
                    end
                end
                S_EI:
                begin
                    ef_reg    <= f_lo - mul_reg[EXP_W+11:12];
                    state_reg <= S_EM;
                end
                S_EM:
                begin
                    state_reg <= S_EW;
                end
                S_EW:
                begin
                    if (sel_reg)
                    begin
                        e2_reg    <= mul_reg[48:24];
                        state_reg <= S_MA;
                    end
                    else
                    begin
                        e1_reg    <= mul_reg[48:24];
                        sel_reg   <= 1'b1;
                        state_reg <= S_EF;
                    end
                end
                S_MA:
                begin
                    g_reg     <= (e1_reg >= e2_reg) ? e1_reg - e2_reg : '0;
                    state_reg <= S_MT;
                end
                S_MT:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    sum_reg   <= sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
                    j_reg     <= j_reg + 1'b1;
                    state_reg <= S_INNER;
                end
                S_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tdata_reg  <= sum_reg[SUM_W-1:8];
                        count_reg    <= '0;
                        sum_reg      <= '0;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/sds_checker.sv =====
// ----------------------------------------------------------------------------
// sds_checker
// Port-level checks for the sensory dissonance sum unit.
// ----------------------------------------------------------------------------
module sds_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a closing transaction always starts the pair walk
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still ready after last partial");

    // a new result only comes out of the pair walk
    a_result_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without computation");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output data changed while stalled");

endmodule

bind sensory_dissonance_sum_unit sds_checker u_sds_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
